// ----- rtl/olid_pkg.sv -----
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and codes for the ordered list block: operation and status
// codes, sequencer states and the payload structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package olid_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_DEL_FIRST = 3'd1,
    FN_DEL_POS   = 3'd2,
    FN_DEL_LAST  = 3'd3,
    FN_DUMP      = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SHIFT = 2'd1,
    S_DUMP  = 2'd2
  } seq_state_t;

  typedef struct packed {
    func_t                    func;
    logic signed [VAL_W-1:0]  value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  element;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/ordered_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of up to DEPTH signed 32-bit values held in a circular RAM.
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries one operation: insert at
//   front, delete first, delete at 1-based position, delete last or dump.
//   Result channel out_valid/out_stall/out_item returns status, element,
//   count after the operation and a last mark.
//   Insert, delete first/last and rejected operations: one registered result
//   after the transfer; the next item can be taken in the following cycle.
//   Delete at position P with N entries: one registered result, then the
//   block is busy while the RAM closes the gap, one entry per cycle through
//   its single write port.
//   Dump of N entries: each element is read from the RAM, then loaded into
//   the output register, one element per cycle while the output is not stalled.
//   A stalled result holds in the output register; the block stops taking
//   items and pauses a dump until it drains.
//   Reset empties the list at once (count zero); RAM contents are not
//   cleared and entries are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_insert_delete #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire olid_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output olid_pkg::out_item_t       out_item
);
  import olid_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  logic              out_valid_r;
  out_item_t         out_item_r;
  logic              out_free;
  logic              res_vld;
  out_item_t         res_item;
  logic              busy;
  logic              ram_wr_en;
  logic [PW-1:0]     ram_wr_addr;
  logic [VAL_W-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [PW-1:0]     ram_rd_addr;
  logic [VAL_W-1:0]  ram_rd_data;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  olid_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .in_stall    (in_stall),
    .out_free    (out_free),
    .res_vld     (res_vld),
    .res_item    (res_item),
    .busy        (busy),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  olid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_item_r <= res_item;
    end
  end

`ifndef SYNTHESIS
  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> out_free)
    else $error("result loaded while output register held");

  // gap-closing writes never hit the entry being read
  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
    else $error("RAM read and write to the same entry");

  // no item taken while a shift or dump is running
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("input taken while sequencer busy");

  // RAM is idle once the sequencer is back to idle and nothing arrives
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !in_valid) |-> (!ram_wr_en && !ram_rd_en && !res_vld))
    else $error("activity without a transfer");
`endif

endmodule

`default_nettype wire

// ----- rtl/olid_ram.sv -----
// ----------------------------------------------------------------------------
// olid_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds its value between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module olid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/olid_ctrl.sv -----
// ----------------------------------------------------------------------------
// olid_ctrl
// Sequencer for the list: keeps head pointer and count, applies single-step
// operations on transfer, and walks the RAM for positional delete (close the
// gap one entry per cycle) and for dump (one element per cycle unless stalled).
// ----------------------------------------------------------------------------
`default_nettype none

module olid_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire olid_pkg::in_item_t           in_item,
  output logic                              in_stall,
  input  wire logic                         out_free,
  output logic                              res_vld,
  output olid_pkg::out_item_t               res_item,
  output logic                              busy,
  output logic                              ram_wr_en,
  output logic [$clog2(DEPTH)-1:0]          ram_wr_addr,
  output logic [olid_pkg::VAL_W-1:0]        ram_wr_data,
  output logic                              ram_rd_en,
  output logic [$clog2(DEPTH)-1:0]          ram_rd_addr,
  input  wire logic [olid_pkg::VAL_W-1:0]   ram_rd_data
);
  import olid_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > CNT_W) ? CW : CNT_W;

  seq_state_t       state_r, state_nxt;
  logic [PW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    end_r, end_nxt;
  logic [CW-1:0]    rd_i_r, rd_i_nxt;
  logic [CW-1:0]    wr_i_r, wr_i_nxt;
  logic             vld_r, vld_nxt;

  logic             accept;
  logic [PW-1:0]    head_dec;
  logic [PW-1:0]    head_inc;
  logic [MW-1:0]    pos_ext;
  logic [MW-1:0]    cnt_ext;
  logic             is_empty;
  logic             pos_ok;
  logic             rd_more;
  logic             dump_done;

  // logical index -> physical address, circular from head
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [PW-1:0] l);
    logic [PW:0] s;
    s = {1'b0, h} + {1'b0, l};
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cnt_out(input logic [CW-1:0] c);
    logic [MW-1:0] e;
    e = MW'(c);
    return e[CNT_W-1:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign busy      = (state_r != S_IDLE);

  assign head_dec  = (head_r == '0) ? PW'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc  = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign pos_ext   = MW'(in_item.position);
  assign cnt_ext   = MW'(count_r);
  assign is_empty  = (count_r == '0);
  assign pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign rd_more   = (rd_i_r < end_r);
  assign dump_done = vld_r && out_free && (wr_i_r == end_r - CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !is_empty) begin
          if (in_item.func == FN_DEL_POS && pos_ok) begin
            state_nxt = S_SHIFT;
          end else if (in_item.func == FN_DUMP) begin
            state_nxt = S_DUMP;
          end
        end
      end
      S_SHIFT: begin
        // last pending write, if any, completes in this cycle
        if (!rd_more) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (dump_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory accesses and results
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    end_nxt     = end_r;
    rd_i_nxt    = rd_i_r;
    wr_i_nxt    = wr_i_r;
    vld_nxt     = vld_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = phys(head_r, wr_i_r[PW-1:0]);
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = phys(head_r, rd_i_r[PW-1:0]);
    res_vld     = 1'b0;
    res_item.status  = ST_OK;
    res_item.element = '0;
    res_item.count   = cnt_out(count_r);
    res_item.last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_vld = 1'b1;
          case (in_item.func)
            FN_INS_FRONT: begin
              if (count_r == CW'(DEPTH)) begin
                res_item.status = ST_FULL;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = head_dec;
                ram_wr_data = in_item.value;
                head_nxt    = head_dec;
                count_nxt   = count_r + CW'(1);
              end
            end
            FN_DEL_FIRST: begin
              if (is_empty) begin
                res_item.status = ST_EMPTY;
              end else begin
                head_nxt  = head_inc;
                count_nxt = count_r - CW'(1);
              end
            end
            FN_DEL_POS: begin
              if (is_empty) begin
                res_item.status = ST_EMPTY;
              end else if (!pos_ok) begin
                res_item.status = ST_INVALID;
              end else begin
                // close the gap: move entries pos..count-1 down by one
                count_nxt = count_r - CW'(1);
                end_nxt   = count_r;
                rd_i_nxt  = pos_ext[CW-1:0];
                wr_i_nxt  = pos_ext[CW-1:0] - CW'(1);
                vld_nxt   = 1'b0;
              end
            end
            FN_DEL_LAST: begin
              if (is_empty) begin
                res_item.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            FN_DUMP: begin
              if (is_empty) begin
                res_item.status = ST_EMPTY;
              end else begin
                res_vld  = 1'b0;
                end_nxt  = count_r;
                rd_i_nxt = '0;
                wr_i_nxt = '0;
                vld_nxt  = 1'b0;
              end
            end
            default: ;
          endcase
          res_item.count = cnt_out(count_nxt);
        end
      end
      S_SHIFT: begin
        // reads run one entry ahead of writes, never the same entry
        if (rd_more) begin
          ram_rd_en = 1'b1;
          rd_i_nxt  = rd_i_r + CW'(1);
        end
        vld_nxt = rd_more;
        if (vld_r) begin
          ram_wr_en = 1'b1;
          wr_i_nxt  = wr_i_r + CW'(1);
        end
      end
      S_DUMP: begin
        if (vld_r && out_free) begin
          res_vld          = 1'b1;
          res_item.element = ram_rd_data;
          res_item.last    = (wr_i_r == end_r - CW'(1));
          wr_i_nxt         = wr_i_r + CW'(1);
        end
        // next read only when the read register is free or being drained
        if (rd_more && (!vld_r || out_free)) begin
          ram_rd_en = 1'b1;
          rd_i_nxt  = rd_i_r + CW'(1);
          vld_nxt   = 1'b1;
        end else begin
          vld_nxt   = vld_r && !out_free;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r  <= end_nxt;
    rd_i_r <= rd_i_nxt;
    wr_i_r <= wr_i_nxt;
  end

endmodule

`default_nettype wire
